>>> src/pcxrle_pkg.sv
// pcxrle_pkg: types, constants and helpers for the PCX RLE framebuffer decoder.
// Used by pcxrle_cfg, pcxrle_addr and pcx_rle_decode_to_framebuffer_top.
`timescale 1ns / 1ps

package pcxrle_pkg;

	localparam int unsigned SCREEN_WIDTH = 320;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 11;
	localparam int unsigned LINE_MAX     = 1024;

	localparam logic [7:0] RUN_MARK = 8'hC0;
	localparam logic [7:0] RUN_MASK = 8'h3F;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_ORIGIN     = 3'd0,
		REG_Y_ORIGIN     = 3'd1,
		REG_IMAGE_WIDTH  = 3'd2,
		REG_IMAGE_HEIGHT = 3'd3,
		REG_LINE_BYTES   = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_DATA  = 1'b1
	} action_t;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] write_address;
		logic [7:0]  pixel_value;
		logic        last_of_run;
		logic        image_done;
	} out_item_t;

	typedef struct packed {
		logic [8:0]  x_origin;
		logic [7:0]  y_origin;
		logic [8:0]  image_width;
		logic [7:0]  image_height;
		logic [10:0] line_bytes;
	} cfg_t;

	// sequencer -> address unit
	typedef struct packed {
		logic start;
		logic step;
	} addr_ctrl_t;

	// address unit -> sequencer
	typedef struct packed {
		logic [15:0] address;
		logic        complete;
		logic        done_next;
	} addr_stat_t;

	// line length clamped to 1..LINE_MAX
	function automatic logic [10:0] eff_line(input logic [10:0] lb);
		logic [10:0] r;
		if (lb == 11'd0) begin
			r = 11'd1;
		end else if (lb > 11'(LINE_MAX)) begin
			r = 11'(LINE_MAX);
		end else begin
			r = lb;
		end
		return r;
	endfunction

endpackage

>>> src/pcxrle_cfg.sv
// pcxrle_cfg: configuration register file, written through a plain write port.
// Depends on pcxrle_pkg.
`timescale 1ns / 1ps

module pcxrle_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcxrle_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcxrle_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output pcxrle_pkg::cfg_t                    cfg
);

	pcxrle_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_origin     <= 9'd0;
			cfg_q.y_origin     <= 8'd0;
			cfg_q.image_width  <= 9'd320;
			cfg_q.image_height <= 8'd200;
			cfg_q.line_bytes   <= 11'd321;
		end else if (cfg_we) begin
			case (pcxrle_pkg::cfg_reg_t'(cfg_index))
				pcxrle_pkg::REG_X_ORIGIN:     cfg_q.x_origin     <= cfg_wdata[8:0];
				pcxrle_pkg::REG_Y_ORIGIN:     cfg_q.y_origin     <= cfg_wdata[7:0];
				pcxrle_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_wdata[8:0];
				pcxrle_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_wdata[7:0];
				pcxrle_pkg::REG_LINE_BYTES:   cfg_q.line_bytes   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/pcxrle_addr.sv
// pcxrle_addr: shared write-address unit; holds address, column and pixel counters
// and advances them by one pixel per step. Depends on pcxrle_pkg.
`timescale 1ns / 1ps

module pcxrle_addr #(
	parameter int unsigned SCREEN_WIDTH = pcxrle_pkg::SCREEN_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pcxrle_pkg::cfg_t        cfg,
	input  pcxrle_pkg::addr_ctrl_t  ctrl,
	output pcxrle_pkg::addr_stat_t  stat
);

	logic [15:0] addr_q;
	logic [9:0]  col_q;
	logic [16:0] pix_q;

	logic [10:0] lb;
	logic [10:0] ncol;
	logic        wrap;
	logic [15:0] row_jump;
	logic [16:0] total;
	logic [16:0] pix_next;
	logic [20:0] start_full;

	always_comb begin
		lb         = pcxrle_pkg::eff_line(cfg.line_bytes);
		ncol       = {1'b0, col_q} + 11'd1;
		wrap       = (ncol >= lb);
		// +1 for the pixel itself, then to the start of the next screen row
		row_jump   = 16'(SCREEN_WIDTH + 1) - {5'd0, lb};
		total      = {8'd0, cfg.image_width} * {9'd0, cfg.image_height};
		pix_next   = pix_q + 17'd1;
		start_full = {13'd0, cfg.y_origin} * 21'(SCREEN_WIDTH)
			+ {12'd0, cfg.x_origin};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 16'd0;
			col_q  <= 10'd0;
			pix_q  <= 17'd0;
		end else if (ctrl.start) begin
			addr_q <= start_full[15:0];
			col_q  <= 10'd0;
			pix_q  <= 17'd0;
		end else if (ctrl.step) begin
			addr_q <= addr_q + (wrap ? row_jump : 16'd1);
			col_q  <= wrap ? 10'd0 : ncol[9:0];
			pix_q  <= pix_next;
		end
	end

	assign stat.address   = addr_q;
	assign stat.complete  = (pix_q >= total);
	assign stat.done_next = (pix_next >= total);

endmodule

>>> src/pcx_rle_decode_to_framebuffer_top.sv
// pcx_rle_decode_to_framebuffer_top: PCX RLE byte stream to framebuffer writes.
// Depends on pcxrle_pkg, pcxrle_cfg, pcxrle_addr.
//
//  channel   signals                          dir  beat
//  byte      byte_valid/byte_ready/byte_item  in   action + one compressed byte
//  wr        wr_valid/wr_ready/wr_item        out  one framebuffer write
//  cfg       cfg_we/cfg_index/cfg_wdata       in   register write, no handshake
//
// Start, run marker and skipped bytes give no write.
// A literal gives its write in the output register.
// A run value byte moves the sequencer into the run state; the address unit
// steps once per write and byte_ready stays low until the run is out.
// A stalled wr beat holds the output register and freezes the sequencer.
// Reset clears the sequencer, counters, config and output valid flag, not the payload.
`timescale 1ns / 1ps

module pcx_rle_decode_to_framebuffer_top #(
	parameter int unsigned SCREEN_WIDTH = pcxrle_pkg::SCREEN_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               byte_valid,
	output logic                               byte_ready,
	input  pcxrle_pkg::in_item_t               byte_item,
	output logic                               wr_valid,
	input  logic                               wr_ready,
	output pcxrle_pkg::out_item_t              wr_item,
	input  logic                               cfg_we,
	input  logic [pcxrle_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pcxrle_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                 state_q;
	logic                   expect_q;
	logic [5:0]             run_len_q;
	logic [5:0]             rem_q;
	logic [7:0]             run_pix_q;
	logic                   out_valid_q;
	pcxrle_pkg::out_item_t  out_q;

	pcxrle_pkg::cfg_t       cfg;
	pcxrle_pkg::addr_ctrl_t actl;
	pcxrle_pkg::addr_stat_t ast;

	logic out_free;
	logic accept;
	logic is_start;
	logic marker;
	logic lit_emit;
	logic run_emit;
	logic run_last;

	pcxrle_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pcxrle_addr #(
		.SCREEN_WIDTH (SCREEN_WIDTH)
	) u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ctrl   (actl),
		.stat   (ast)
	);

	always_comb begin
		out_free   = !out_valid_q || wr_ready;
		byte_ready = (state_q == ST_IDLE) && out_free;
		accept     = byte_valid && byte_ready;
		is_start   = (byte_item.action == pcxrle_pkg::ACT_START);
		marker     = ((byte_item.data_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK);
		lit_emit   = accept && !is_start && !ast.complete && !expect_q && !marker;
		run_emit   = (state_q == ST_RUN) && out_free;
		run_last   = (rem_q == 6'd1) || ast.done_next;
		actl.start = accept && is_start;
		actl.step  = lit_emit || run_emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			expect_q    <= 1'b0;
			run_len_q   <= 6'd0;
			rem_q       <= 6'd0;
			run_pix_q   <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_start) begin
							expect_q  <= 1'b0;
							run_len_q <= 6'd0;
						end else if (!ast.complete) begin
							if (expect_q) begin
								expect_q  <= 1'b0;
								run_len_q <= 6'd0;
								// zero count swallows the value byte
								if (run_len_q != 6'd0) begin
									state_q   <= ST_RUN;
									rem_q     <= run_len_q;
									run_pix_q <= byte_item.data_byte;
								end
							end else if (marker) begin
								run_len_q <= byte_item.data_byte[5:0] & pcxrle_pkg::RUN_MASK[5:0];
								expect_q  <= 1'b1;
							end
						end
					end
				end
				ST_RUN: begin
					if (run_emit) begin
						rem_q <= rem_q - 6'd1;
						if (run_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (actl.step) begin
				out_valid_q <= 1'b1;
			end else if (wr_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (actl.step) begin
			out_q.write_address <= ast.address;
			out_q.pixel_value   <= lit_emit ? byte_item.data_byte : run_pix_q;
			out_q.last_of_run   <= lit_emit ? 1'b1 : run_last;
			out_q.image_done    <= ast.done_next;
		end
	end

	assign wr_valid = out_valid_q;
	assign wr_item  = out_q;

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rem_q != 6'd0))
		else $error("run state with no writes left");

	a_no_accept_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !byte_ready)
		else $error("byte accepted while a run is being written");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_valid && wr_item.image_done) |-> wr_item.last_of_run)
		else $error("image_done write not marked last_of_run");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(run_emit && run_last) |=> (state_q == ST_IDLE))
		else $error("sequencer stayed in run after final write");

endmodule
